>>> src/symmetric_tridiagonal_solver_top_defines.svh
// Assertion macros for the symmetric tridiagonal solver.
`ifndef SYMMETRIC_TRIDIAGONAL_SOLVER_TOP_DEFINES_SVH
`define SYMMETRIC_TRIDIAGONAL_SOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Implication or plain property, sampled on clk, off while arst_n is low.
`define STS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sts property failed");
// Condition that must never be seen.
`define STS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sts forbidden condition seen");
`else
`define STS_ASSERT(lbl, prop)
`define STS_NEVER(lbl, cond)
`endif
`endif

>>> src/sts_pkg.sv
// Shared types, constants and helpers of the symmetric tridiagonal solver.
`default_nettype none
package sts_pkg;
	localparam int MAX_SIZE  = 64;
	localparam int IDX_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 24;
	localparam int PROD_W    = 41;
	localparam int ACC_W     = 42;
	localparam int DIV_STEPS = WORD_W + FRAC_W;
	localparam int DCNT_W    = 6;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_FACTOR = 2'd1;
	localparam logic [1:0] OP_SOLVE  = 2'd2;
	localparam logic [1:0] OP_MULT   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_NOTF = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [IDX_W-1:0]        element_index;
		logic signed [WORD_W-1:0] diag_value;
		logic signed [WORD_W-1:0] upper_value;
		logic signed [WORD_W-1:0] vector_value;
		logic                    vector_last;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [IDX_W-1:0]        result_index;
		logic                    result_last;
		logic [1:0]              status;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_REPORT,
		S_FA_INIT, S_FA_P0, S_FA_CHK, S_FA_RD, S_FA_DS, S_FA_DW, S_FA_W,
		S_CP_RD, S_CP_WR,
		S_SF_INIT, S_SF_I0, S_SF_RD, S_SF_M, S_SF_W,
		S_SB_START, S_SB_D0, S_SB_RD, S_SB_M, S_SB_S, S_SB_DW,
		S_MU_INIT, S_MU_I0, S_MU_RD, S_MU_L1, S_MU_L2, S_MU_L3, S_MU_L4,
		S_EM_RD, S_EM_LD
	} state_t;

	// Clamp a wide signed value to the word range.
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-WORD_W:0] top;
		logic signed [WORD_W-1:0] r;
		top = v[ACC_W-1:WORD_W-1];
		if (top == '0 || top == '1)
			r = v[WORD_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(WORD_W-1){1'b0}}};
		else
			r = {1'b0, {(WORD_W-1){1'b1}}};
		return r;
	endfunction
endpackage
`default_nettype wire

>>> src/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sts_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> src/sts_mul.sv
// Shared fixed-point multiplier: exact product, round half up, registered.
`default_nettype none
module sts_mul import sts_pkg::*; (
	input  wire logic               clk,
	input  wire logic signed [WORD_W-1:0] a,
	input  wire logic signed [WORD_W-1:0] b,
	output logic signed [PROD_W-1:0] p
);
	localparam logic signed [2*WORD_W-1:0] HALF = 64'sd1 <<< (FRAC_W - 1);
	logic signed [2*WORD_W-1:0] prod;
	logic signed [2*WORD_W-1:0] rnd;
	logic signed [PROD_W-1:0]   p_q;

	assign prod = a * b;
	assign rnd  = (prod + HALF) >>> FRAC_W;

	always_ff @(posedge clk) begin
		p_q <= rnd[PROD_W-1:0];
	end

	assign p = p_q;
endmodule
`default_nettype wire

>>> src/sts_div.sv
// Shared fixed-point divider: restoring, one quotient bit per cycle.
`default_nettype none
module sts_div import sts_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic signed [WORD_W-1:0] a,
	input  wire logic signed [WORD_W-1:0] b,
	output logic signed [WORD_W-1:0]      q,
	output logic                          done,
	output logic                          busy
);
	logic                 busy_q, done_q, neg_q, zero_q;
	logic [DCNT_W-1:0]    cnt_q;
	logic [WORD_W-1:0]    den_q, rem_q;
	logic [DIV_STEPS-1:0] num_q;
	logic signed [WORD_W-1:0] q_q;
	logic [WORD_W-1:0]    amag, bmag;
	logic [WORD_W:0]      rem_n;
	logic                 ge;
	logic [WORD_W:0]      rem_sub;
	logic [DIV_STEPS-1:0] qf;
	logic signed [WORD_W-1:0] qsat;

	assign amag    = a[WORD_W-1] ? WORD_W'(-a) : a;
	assign bmag    = b[WORD_W-1] ? WORD_W'(-b) : b;
	assign rem_n   = {rem_q, num_q[DIV_STEPS-1]};
	assign ge      = rem_n >= {1'b0, den_q};
	assign rem_sub = rem_n - {1'b0, den_q};
	assign qf      = {num_q[DIV_STEPS-2:0], ge};

	always_comb begin
		if (zero_q)
			qsat = '0;
		else if (neg_q) begin
			if (qf[DIV_STEPS-1:WORD_W] != '0 || (qf[WORD_W-1] && qf[WORD_W-2:0] != '0))
				qsat = {1'b1, {(WORD_W-1){1'b0}}};
			else
				qsat = WORD_W'(-qf[WORD_W-1:0]);
		end else begin
			if (qf[DIV_STEPS-1:WORD_W-1] != '0)
				qsat = {1'b0, {(WORD_W-1){1'b1}}};
			else
				qsat = qf[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			den_q  <= bmag;
			num_q  <= {amag, {FRAC_W{1'b0}}};
			rem_q  <= '0;
			neg_q  <= a[WORD_W-1] ^ b[WORD_W-1];
			zero_q <= (b == '0);
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[WORD_W-1:0] : rem_n[WORD_W-1:0];
			num_q <= qf;
			if (cnt_q == DCNT_W'(DIV_STEPS - 1))
				q_q <= qsat;
		end
	end

	assign q    = q_q;
	assign done = done_q;
	assign busy = busy_q;
endmodule
`default_nettype wire

>>> src/symmetric_tridiagonal_solver_top.sv
// Top level of the symmetric tridiagonal solver: sequencer, stores, output register.
// Usage: items arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data; cfg_we/cfg_data set the matrix size n.
// A row load or a non-final vector element is taken in the idle state and gives no result.
// A factor command, unless the matrix is already factored, walks the rows with
// the shared divider and multiplier, commits the pivots if none is zero, then
// gives one result with the status.
// A final vector element starts a solve (a forward pass, then a back pass with
// a divide per row) or a multiply, or gives only a not-factored status if the
// matrix is not factored; the n results then leave one at a time while out_stall is low.
// The divider loop produces one quotient bit per cycle.
// in_stall is high whenever the sequencer is not idle. A result waits in the
// output register while out_stall is high; the sequencer holds meanwhile,
// and a new item can be taken while the last result still waits.
// Reset (arst_n low) clears the factored flag, sets n to 64 and empties the
// output register; the stores keep no reset value and must be loaded.
`default_nettype none
`include "symmetric_tridiagonal_solver_top_defines.svh"
module symmetric_tridiagonal_solver_top import sts_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data
);
	state_t state_q, state_d;
	logic [IDX_W-1:0]  i_q;
	logic [SIZE_W-1:0] size_q;
	logic              factored_q;
	logic              out_valid_q;
	out_item_t         out_q, out_nxt;
	logic              out_ld, out_free;
	logic [IDX_W-1:0]  rep_idx_q;
	logic [1:0]        rep_st_q;
	logic signed [WORD_W-1:0] pvcur_q, yprev_q, xnext_q, vcur_q, vnext_q;
	logic signed [WORD_W-1:0] o_a_q, o_b_q, t_q;
	logic signed [PROD_W-1:0] acc_q;

	logic [SIZE_W-1:0] n_w;
	logic [IDX_W-1:0]  nm1;
	logic              last_i, in_acc;

	logic                     piv_we, upr_we, mlt_we, vec_we, itm_we, xs_we, pvs_we;
	logic [IDX_W-1:0]         piv_wa, mlt_wa, vec_wa, itm_wa, xs_wa, pvs_wa;
	logic [IDX_W-1:0]         piv_ra, upr_ra, mlt_ra, vec_ra, itm_ra, xs_ra, pvs_ra;
	logic signed [WORD_W-1:0] piv_wd, mlt_wd, vec_wd, itm_wd, xs_wd, pvs_wd;
	logic signed [WORD_W-1:0] piv_rd, upr_rd, mlt_rd, vec_rd, itm_rd, xs_rd, pvs_rd;

	logic signed [WORD_W-1:0] mul_a, mul_b, div_a, div_b, div_q;
	logic signed [PROD_W-1:0] p_q;
	logic                     div_go, div_done, div_busy;
	logic signed [WORD_W-1:0] diff_y, mu_t, mu_x;

	assign n_w = (size_q < SIZE_W'(2)) ? SIZE_W'(2) :
		(size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
	assign nm1      = IDX_W'(n_w - SIZE_W'(1));
	assign last_i   = (i_q == nm1);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign diff_y = sat_word(ACC_W'(o_a_q) - ACC_W'(p_q));
	assign mu_t   = sat_word(ACC_W'(acc_q) + ACC_W'(p_q));
	assign mu_x   = sat_word(ACC_W'(t_q) + ACC_W'(p_q));

	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_piv (.clk(clk), .we(piv_we), .waddr(piv_wa),
		.wdata(piv_wd), .raddr(piv_ra), .rdata(piv_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_upr (.clk(clk), .we(upr_we), .waddr(in_data.element_index),
		.wdata(in_data.upper_value), .raddr(upr_ra), .rdata(upr_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_mlt (.clk(clk), .we(mlt_we), .waddr(mlt_wa),
		.wdata(mlt_wd), .raddr(mlt_ra), .rdata(mlt_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_vec (.clk(clk), .we(vec_we), .waddr(vec_wa),
		.wdata(vec_wd), .raddr(vec_ra), .rdata(vec_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_itm (.clk(clk), .we(itm_we), .waddr(itm_wa),
		.wdata(itm_wd), .raddr(itm_ra), .rdata(itm_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_xs (.clk(clk), .we(xs_we), .waddr(xs_wa),
		.wdata(xs_wd), .raddr(xs_ra), .rdata(xs_rd));
	sts_ram #(.W(WORD_W), .D(MAX_SIZE)) u_pvs (.clk(clk), .we(pvs_we), .waddr(pvs_wa),
		.wdata(pvs_wd), .raddr(pvs_ra), .rdata(pvs_rd));

	sts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p_q));

	sts_div u_div (.clk(clk), .arst_n(arst_n), .go(div_go), .a(div_a), .b(div_b),
		.q(div_q), .done(div_done), .busy(div_busy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		piv_we = 1'b0; upr_we = 1'b0; mlt_we = 1'b0; vec_we = 1'b0;
		itm_we = 1'b0; xs_we = 1'b0; pvs_we = 1'b0;
		piv_wa = i_q; mlt_wa = i_q; vec_wa = in_data.element_index;
		itm_wa = i_q; xs_wa = i_q; pvs_wa = i_q + 1'b1;
		piv_wd = in_data.diag_value; mlt_wd = div_q; vec_wd = in_data.vector_value;
		itm_wd = diff_y; xs_wd = div_q; pvs_wd = diff_y;
		piv_ra = i_q; upr_ra = i_q; mlt_ra = i_q - 1'b1; vec_ra = i_q;
		itm_ra = i_q; xs_ra = i_q; pvs_ra = i_q;
		mul_a = '0; mul_b = '0;
		div_go = 1'b0; div_a = '0; div_b = '0;
		out_ld = 1'b0;
		out_nxt = '{result_value: '0, result_index: rep_idx_q, result_last: 1'b1,
			status: rep_st_q};
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_data.opcode)
						OP_LOAD: begin
							piv_we = 1'b1;
							piv_wa = in_data.element_index;
							upr_we = 1'b1;
						end
						OP_FACTOR: begin
							state_d = factored_q ? S_REPORT : S_FA_INIT;
						end
						default: begin
							vec_we = 1'b1;
							if (in_data.vector_last) begin
								if (!factored_q)
									state_d = S_REPORT;
								else if (in_data.opcode == OP_SOLVE)
									state_d = S_SF_INIT;
								else
									state_d = S_MU_INIT;
							end
						end
					endcase
				end
			end
			S_REPORT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FA_INIT: begin
				piv_ra  = '0;
				state_d = S_FA_P0;
			end
			S_FA_P0: state_d = S_FA_CHK;
			S_FA_CHK: begin
				if (pvcur_q == '0)
					state_d = S_REPORT;
				else if (last_i)
					state_d = S_CP_RD;
				else
					state_d = S_FA_RD;
			end
			S_FA_RD: begin
				piv_ra  = i_q + 1'b1;
				state_d = S_FA_DS;
			end
			S_FA_DS: begin
				div_go  = 1'b1;
				div_a   = upr_rd;
				div_b   = pvcur_q;
				state_d = S_FA_DW;
			end
			S_FA_DW: begin
				mul_a = div_q;
				mul_b = o_b_q;
				if (div_done)
					state_d = S_FA_W;
			end
			S_FA_W: begin
				mlt_we  = 1'b1;
				pvs_we  = 1'b1;
				state_d = S_FA_CHK;
			end
			S_CP_RD: state_d = S_CP_WR;
			S_CP_WR: begin
				piv_we  = 1'b1;
				piv_wd  = pvs_rd;
				state_d = last_i ? S_REPORT : S_CP_RD;
			end
			S_SF_INIT: begin
				vec_ra  = '0;
				state_d = S_SF_I0;
			end
			S_SF_I0: begin
				itm_we  = 1'b1;
				itm_wa  = '0;
				itm_wd  = vec_rd;
				state_d = S_SF_RD;
			end
			S_SF_RD: state_d = S_SF_M;
			S_SF_M: begin
				mul_a   = mlt_rd;
				mul_b   = yprev_q;
				state_d = S_SF_W;
			end
			S_SF_W: begin
				itm_we  = 1'b1;
				state_d = last_i ? S_SB_START : S_SF_RD;
			end
			S_SB_START: state_d = S_SB_D0;
			S_SB_D0: begin
				div_go  = 1'b1;
				div_a   = yprev_q;
				div_b   = piv_rd;
				state_d = S_SB_DW;
			end
			S_SB_DW: begin
				if (div_done) begin
					xs_we   = 1'b1;
					state_d = (i_q == '0) ? S_EM_RD : S_SB_RD;
				end
			end
			S_SB_RD: state_d = S_SB_M;
			S_SB_M: begin
				mul_a   = upr_rd;
				mul_b   = xnext_q;
				state_d = S_SB_S;
			end
			S_SB_S: begin
				div_go  = 1'b1;
				div_a   = diff_y;
				div_b   = o_b_q;
				state_d = S_SB_DW;
			end
			S_MU_INIT: begin
				vec_ra  = '0;
				state_d = S_MU_I0;
			end
			S_MU_I0: state_d = S_MU_RD;
			S_MU_RD: begin
				vec_ra  = i_q + 1'b1;
				state_d = S_MU_L1;
			end
			S_MU_L1: begin
				mul_a   = piv_rd;
				mul_b   = vcur_q;
				state_d = S_MU_L2;
			end
			S_MU_L2: begin
				mul_a   = o_a_q;
				mul_b   = vnext_q;
				state_d = S_MU_L3;
			end
			S_MU_L3: begin
				mul_a   = o_b_q;
				mul_b   = yprev_q;
				state_d = S_MU_L4;
			end
			S_MU_L4: begin
				xs_we   = 1'b1;
				xs_wd   = (i_q == '0) ? t_q : mu_x;
				state_d = last_i ? S_EM_RD : S_MU_RD;
			end
			S_EM_RD: state_d = S_EM_LD;
			S_EM_LD: begin
				if (out_free) begin
					out_ld  = 1'b1;
					out_nxt = '{result_value: xs_rd, result_index: i_q,
						result_last: last_i, status: ST_OK};
					state_d = last_i ? S_IDLE : S_EM_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			size_q      <= SIZE_W'(MAX_SIZE);
			factored_q  <= 1'b0;
			out_valid_q <= 1'b0;
			rep_idx_q   <= '0;
			rep_st_q    <= ST_OK;
		end else begin
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				size_q     <= cfg_data;
				factored_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					i_q       <= '0;
					rep_idx_q <= '0;
					if (in_acc) begin
						case (in_data.opcode)
							OP_LOAD: factored_q <= 1'b0;
							OP_FACTOR: rep_st_q <= ST_DONE;
							default: rep_st_q <= ST_NOTF;
						endcase
					end
				end
				S_FA_CHK: begin
					if (pvcur_q == '0) begin
						rep_st_q  <= ST_ZERO;
						rep_idx_q <= i_q;
					end else if (last_i)
						i_q <= IDX_W'(1);
				end
				S_FA_W: i_q <= i_q + 1'b1;
				S_CP_WR: begin
					if (last_i) begin
						factored_q <= 1'b1;
						rep_st_q   <= ST_DONE;
						rep_idx_q  <= '0;
					end else
						i_q <= i_q + 1'b1;
				end
				S_SF_I0: i_q <= IDX_W'(1);
				S_SF_W: if (!last_i) i_q <= i_q + 1'b1;
				S_SB_DW: begin
					// Stop at row 0 so the emit pass starts there.
					if (div_done && i_q != '0)
						i_q <= i_q - 1'b1;
				end
				S_MU_L4: i_q <= last_i ? '0 : i_q + 1'b1;
				S_EM_LD: if (out_free) i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (out_ld)
			out_q <= out_nxt;
		case (state_q)
			S_FA_P0: pvcur_q <= piv_rd;
			S_FA_DS: begin
				o_a_q <= piv_rd;
				o_b_q <= upr_rd;
			end
			S_FA_W: pvcur_q <= diff_y;
			S_SF_I0: yprev_q <= vec_rd;
			S_SF_M: o_a_q <= vec_rd;
			S_SF_W: yprev_q <= diff_y;
			S_SB_DW: if (div_done) xnext_q <= div_q;
			S_SB_M: begin
				o_a_q <= itm_rd;
				o_b_q <= piv_rd;
			end
			S_MU_I0: vcur_q <= vec_rd;
			S_MU_L1: begin
				o_a_q   <= upr_rd;
				o_b_q   <= mlt_rd;
				vnext_q <= last_i ? '0 : vec_rd;
			end
			S_MU_L2: acc_q <= p_q;
			S_MU_L3: t_q <= mu_t;
			S_MU_L4: begin
				yprev_q <= t_q;
				vcur_q  <= vnext_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`STS_ASSERT(a_load_clears_flag, (in_acc && in_data.opcode == OP_LOAD) |=> !factored_q)
	`STS_NEVER(a_div_restart, div_go && div_busy)
	`STS_ASSERT(a_mid_vector_ok, (out_valid && !out_data.result_last) |-> out_data.status == ST_OK)
	`STS_NEVER(a_out_overrun, out_ld && out_valid_q && out_stall)
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the symmetric tridiagonal solver: stimulus, prediction, checks.
`default_nettype none

class sts_scoreboard;
	longint pivots[64], uppers[64], mults[64], vec[64], partial[64];
	bit factored;
	int unsigned size;
	sts_pkg::out_item_t pending[$];
	int errors;

	function new();
		factored = 0;
		size = 64;
		errors = 0;
	endfunction

	function longint clip(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Round to nearest by adding half an LSB, then floor.
	function longint qmul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< 23);
		return p >>> 24;
	endfunction

	function longint qdiv(longint a, longint b);
		if (b == 0) return 0;
		return clip((a <<< 24) / b);
	endfunction

	function void configure(int unsigned v);
		size = v;
		factored = 0;
	endfunction

	function int unsigned rows();
		if (size < 2) return 2;
		if (size > 64) return 64;
		return size;
	endfunction

	function void push(longint v, int unsigned idx, bit last, logic [1:0] st);
		sts_pkg::out_item_t r;
		r.result_value = v[31:0];
		r.result_index = idx[5:0];
		r.result_last = last;
		r.status = st;
		pending.push_back(r);
	endfunction

	// Returns the row of the first zero pivot, or -1 once the factors are committed.
	function int eliminate(int unsigned n);
		longint pv[64], ml[64], q;
		pv = pivots;
		ml = mults;
		for (int i = 0; i + 1 < n; i++) begin
			if (pv[i] == 0) return i;
			q = qdiv(uppers[i], pv[i]);
			pv[i+1] = clip(pv[i+1] - qmul(q, uppers[i]));
			ml[i] = q;
		end
		if (pv[n-1] == 0) return n - 1;
		pivots = pv;
		mults = ml;
		factored = 1;
		return -1;
	endfunction

	function void note_input(sts_pkg::in_item_t it);
		int unsigned n, idx;
		int bad;
		longint x[64];
		n = rows();
		idx = it.element_index;
		if (it.opcode == sts_pkg::OP_LOAD) begin
			pivots[idx] = it.diag_value;
			uppers[idx] = it.upper_value;
			factored = 0;
			return;
		end
		if (it.opcode == sts_pkg::OP_FACTOR) begin
			bad = -1;
			if (!factored) bad = eliminate(n);
			if (bad >= 0) push(0, bad, 1, sts_pkg::ST_ZERO);
			else push(0, 0, 1, sts_pkg::ST_DONE);
			return;
		end
		vec[idx] = it.vector_value;
		if (!it.vector_last) return;
		if (!factored) begin
			push(0, 0, 1, sts_pkg::ST_NOTF);
			return;
		end
		if (it.opcode == sts_pkg::OP_SOLVE) begin
			partial[0] = vec[0];
			for (int i = 1; i < n; i++)
				partial[i] = clip(vec[i] - qmul(mults[i-1], partial[i-1]));
			x[n-1] = qdiv(partial[n-1], pivots[n-1]);
			for (int i = n - 2; i >= 0; i--)
				x[i] = qdiv(clip(partial[i] - qmul(uppers[i], x[i+1])), pivots[i]);
		end else begin
			for (int i = 0; i + 1 < n; i++)
				partial[i] = clip(qmul(pivots[i], vec[i]) + qmul(uppers[i], vec[i+1]));
			partial[n-1] = clip(qmul(pivots[n-1], vec[n-1]));
			x[0] = partial[0];
			for (int i = 1; i < n; i++)
				x[i] = clip(partial[i] + qmul(mults[i-1], partial[i-1]));
		end
		for (int i = 0; i < n; i++)
			push(x[i], i, i + 1 == n, sts_pkg::ST_OK);
	endfunction

	function void check(sts_pkg::out_item_t got);
		sts_pkg::out_item_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: value %h index %0d last %0d status %0d",
					got.result_value, got.result_index, got.result_last, got.status);
			return;
		end
		want = pending.pop_front();
		if (got.result_value !== want.result_value || got.result_index !== want.result_index ||
				got.result_last !== want.result_last || got.status !== want.status) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
					want.result_value, want.result_index, want.result_last, want.status,
					got.result_value, got.result_index, got.result_last, got.status);
		end
	endfunction
endclass

module tb_top;
	import sts_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	sts_scoreboard sb;
	int idle_mode;
	int sent;

	symmetric_tridiagonal_solver_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		case (idle_mode)
			2: out_stall = ($urandom_range(99) < 67);
			3: out_stall = ($urandom_range(99) < 16);
			default: out_stall = 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(out_data);
	end

	initial begin
		#100000000;
		$display("tb_top failed");
		$finish;
	end

	function automatic in_item_t mk(logic [1:0] op, int unsigned idx, logic [31:0] d,
			logic [31:0] u, logic [31:0] v, bit last);
		in_item_t it;
		it.opcode = op;
		it.element_index = idx[5:0];
		it.diag_value = d;
		it.upper_value = u;
		it.vector_value = v;
		it.vector_last = last;
		return it;
	endfunction

	// Called and returns at a falling edge; holds the transaction until accepted.
	task automatic send(in_item_t it);
		while ((idle_mode == 1 && $urandom_range(99) < 67) ||
				(idle_mode == 3 && $urandom_range(99) < 16)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_size(int unsigned n);
		drain();
		cfg_we = 1'b1;
		cfg_data = n[SIZE_W-1:0];
		@(posedge clk);
		sb.configure(n);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] well_diag();
		logic [31:0] m;
		m = ($urandom_range(5) + 3) << 24 | $urandom_range(24'hFFFFFF);
		return $urandom_range(1) ? -m : m;
	endfunction

	function automatic logic [31:0] modest(int unsigned mag);
		int v;
		v = $urandom_range(mag << 24);
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic noise();
		send(mk(2'($urandom_range(3)), $urandom_range(63), $urandom, $urandom, $urandom,
			$urandom_range(3) == 0));
	endtask

	// Load, factor, then stream one or more vectors; sometimes break the sequence.
	task automatic problem(int unsigned n);
		int unsigned order[$];
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(14) == 0)
				send(mk(OP_LOAD, i, 32'd0, modest(1), 32'd0, 0));
			else
				send(mk(OP_LOAD, i, well_diag(), modest(1), $urandom, 1'($urandom_range(1))));
		end
		if ($urandom_range(9) != 0)
			send(mk(OP_FACTOR, $urandom_range(63), $urandom, $urandom, $urandom,
				1'($urandom_range(1))));
		repeat ((n > 16) ? 1 : $urandom_range(3) + 1) begin
			order.delete();
			for (int i = 0; i < n; i++) order.push_back(i);
			order.shuffle();
			foreach (order[k])
				send(mk($urandom_range(1) ? OP_SOLVE : OP_MULT, order[k], $urandom, $urandom,
					modest(8), 0));
			send(mk($urandom_range(1) ? OP_SOLVE : OP_MULT, $urandom_range(n - 1), $urandom,
				$urandom, modest(8), 1));
			if ($urandom_range(7) == 0) noise();
		end
	endtask

	initial begin
		int unsigned sizes[10] = '{2, 64, 5, 3, 8, 13, 4, 2, 6, 31};
		int budget;
		sb = new();
		idle_mode = 0;
		sent = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill every entry of the diagonal, upper and vector stores once, so none is read unwritten.
		for (int i = 0; i < 64; i++) begin
			send(mk(OP_LOAD, i, well_diag(), modest(1), 32'd0, 0));
			send(mk(OP_SOLVE, i, 32'd0, 32'd0, modest(8), 0));
		end

		set_size(4);
		send(mk(OP_SOLVE, 0, 32'd0, 32'd0, 32'h7FFFFFFF, 1));
		send(mk(OP_LOAD, 2, 32'd0, 32'h0100_0000, 32'd0, 0));
		send(mk(OP_FACTOR, 0, 32'd0, 32'd0, 32'd0, 0));
		send(mk(OP_LOAD, 2, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1));
		send(mk(OP_LOAD, 3, 32'h80000000, 32'h7FFFFFFF, 32'd0, 0));
		send(mk(OP_FACTOR, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
		send(mk(OP_FACTOR, 0, 32'd0, 32'd0, 32'd0, 0));
		send(mk(OP_SOLVE, 0, 32'd0, 32'd0, 32'h80000000, 0));
		send(mk(OP_SOLVE, 63, 32'd0, 32'd0, 32'h12345678, 0));
		send(mk(OP_SOLVE, 3, 32'd0, 32'd0, 32'h7FFFFFFF, 1));
		send(mk(OP_MULT, 1, 32'd0, 32'd0, 32'h80000000, 1));
		send(mk(OP_LOAD, 63, 32'd0, 32'd0, 32'd0, 0));
		send(mk(OP_MULT, 2, 32'd0, 32'd0, 32'd0, 1));
		send(mk(OP_FACTOR, 0, 32'd0, 32'd0, 32'd0, 0));
		send(mk(OP_MULT, 0, 32'd0, 32'd0, 32'h0100_0000, 1));

		// Pause with nothing outstanding before resuming.
		drain();

		budget = 15;
		foreach (sizes[p]) begin
			set_size(sizes[p]);
			idle_mode = p % 4;
			budget += (sizes[p] == 64) ? 10 : 20;
			do begin
				if ($urandom_range(5) == 0) noise();
				else problem(sizes[p]);
			end while (sent - 128 < budget && sizes[p] != 64);
		end
		idle_mode = 0;
		while (sent < 450) begin
			if ($urandom_range(4) == 0) noise();
			else problem($urandom_range(6) + 2 <= 31 ? sb.rows() : 2);
		end

		drain();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/sts_pkg.sv
src/sts_ram.sv
src/sts_mul.sv
src/sts_div.sv
src/symmetric_tridiagonal_solver_top.sv
tb/tb_top.sv
